// File: sv/mrex_pkg.sv
// shared types and constants for the r-type execute unit
package mrex_pkg;

    localparam int unsigned XLEN = 32;
    localparam int unsigned REG_COUNT = 32;
    localparam int unsigned REG_IDX_W = 5;
    localparam logic [31:0] FAULT_TARGET_RESET = 32'h2000_0000;

    typedef enum logic [1:0] {
        FAULT_NONE     = 2'd0,
        FAULT_OVERFLOW = 2'd1,
        FAULT_ALIGN    = 2'd2,
        FAULT_RESERVED = 2'd3
    } fault_t;

    typedef enum logic [5:0] {
        FN_SLL   = 6'h00,
        FN_SRL   = 6'h02,
        FN_SRA   = 6'h03,
        FN_SLLV  = 6'h04,
        FN_SRLV  = 6'h06,
        FN_SRAV  = 6'h07,
        FN_JR    = 6'h08,
        FN_JALR  = 6'h09,
        FN_MFHI  = 6'h10,
        FN_MTHI  = 6'h11,
        FN_MFLO  = 6'h12,
        FN_MTLO  = 6'h13,
        FN_MULT  = 6'h18,
        FN_MULTU = 6'h19,
        FN_DIV   = 6'h1A,
        FN_DIVU  = 6'h1B,
        FN_ADD   = 6'h20,
        FN_ADDU  = 6'h21,
        FN_SUB   = 6'h22,
        FN_SUBU  = 6'h23,
        FN_AND   = 6'h24,
        FN_OR    = 6'h25,
        FN_XOR   = 6'h26,
        FN_SLT   = 6'h2A,
        FN_SLTU  = 6'h2B
    } funct_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_ITER,
        ST_FINISH,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        IT_NONE,
        IT_MUL,
        IT_DIV
    } iter_op_t;

    typedef struct packed {
        logic     start;
        iter_op_t op;
        logic     sign_a;
        logic     sign_b;
    } iter_ctrl_t;

    typedef struct packed {
        logic        done;
        logic [31:0] hi;
        logic [31:0] lo;
    } iter_stat_t;

endpackage

// File: sv/mips_rtype_execute_unit.sv
// top level: r-type execute sequencer with register file, hi/lo and iterative unit
// flow: an accepted item passes the read, execute and finish states to m_axis_tvalid in out;
// mult/multu/div/divu (div only with a nonzero divisor) add the iter state (32 steps, sign fix-up)
// one item at a time: the next item is accepted only after the result is taken in out;
// s_axis_tready is high only in idle, once the register file clearing pass is done
// reset: synchronous active-low aresetn clears control and hi/lo and loads fault_target
// with FAULT_TARGET_INIT; a clearing pass then zeroes the register file before the first transfer
module mips_rtype_execute_unit #(
    parameter logic [31:0] FAULT_TARGET_INIT = mrex_pkg::FAULT_TARGET_RESET
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // instruction[31:0], pc[63:32], next_pc_in[95:64], load_index[100:96],
    // load_value[132:101], zero fill
    input  logic [135:0] s_axis_tdata,
    input  logic         s_axis_tuser,   // command
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // fault[1:0], next_pc_out[33:2], wrote_reg[34], dest_index[39:35],
    // dest_value[71:40], hi_value[103:72], lo_value[135:104]
    output logic [135:0] m_axis_tdata
);

    mrex_pkg::state_t state_reg, state_next;
    logic [31:0] fault_target_reg;
    logic [31:0] hi_reg, hi_next, lo_reg, lo_next;
    logic [5:0]  clr_reg, clr_next;
    logic        cmd_reg;
    logic [31:0] ins_reg, pc_reg, npc_reg, ldv_reg;
    logic [4:0]  ldi_reg;
    logic [135:0] out_reg, out_next;

    logic        rf_we;
    logic [4:0]  rf_waddr;
    logic [31:0] rf_wdata, a, b;
    mrex_pkg::iter_ctrl_t ictrl;
    mrex_pkg::iter_stat_t istat;

    logic [4:0]  rs, rt, rd, sh, amt;
    logic [5:0]  fn;
    logic [32:0] sum, dif;
    logic [31:0] shres;
    logic [1:0]  fault;
    logic [31:0] next_pc, dv;
    logic        wr;
    logic [4:0]  di;

    assign rs = ins_reg[25:21];
    assign rt = ins_reg[20:16];
    assign rd = ins_reg[15:11];
    assign sh = ins_reg[10:6];
    assign fn = ins_reg[5:0];

    mrex_regfile u_rf (
        .aclk(aclk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
        .raddr_a(rs), .raddr_b(rt), .rdata_a(a), .rdata_b(b)
    );

    mrex_iter_unit u_iter (
        .aclk(aclk), .aresetn(aresetn), .ctrl(ictrl), .op_a(a), .op_b(b), .stat(istat)
    );

    always_comb begin
        sum = {1'b0, a} + {1'b0, b};
        dif = {1'b0, a} - {1'b0, b};
        amt = (fn[2]) ? a[4:0] : sh;
        unique case (fn[1:0])
            2'b10:   shres = b >> amt;
            2'b11:   shres = 32'($signed(b) >>> amt);
            default: shres = b << amt;
        endcase
        fault = mrex_pkg::FAULT_NONE;
        next_pc = npc_reg + 32'd4;
        wr = 1'b0;
        dv = 32'd0;
        di = rd;
        case (fn)
            mrex_pkg::FN_ADD: begin
                if ((a[31] ^ sum[31]) & (b[31] ^ sum[31])) fault = mrex_pkg::FAULT_OVERFLOW;
                else begin wr = 1'b1; dv = sum[31:0]; end
            end
            mrex_pkg::FN_ADDU: begin wr = 1'b1; dv = sum[31:0]; end
            mrex_pkg::FN_SUB: begin
                if ((a[31] ^ b[31]) & (a[31] ^ dif[31])) fault = mrex_pkg::FAULT_OVERFLOW;
                else begin wr = 1'b1; dv = dif[31:0]; end
            end
            mrex_pkg::FN_SUBU: begin wr = 1'b1; dv = dif[31:0]; end
            mrex_pkg::FN_AND: begin wr = 1'b1; dv = a & b; end
            mrex_pkg::FN_OR:  begin wr = 1'b1; dv = a | b; end
            mrex_pkg::FN_XOR: begin wr = 1'b1; dv = a ^ b; end
            mrex_pkg::FN_SLT: begin
                wr = 1'b1; dv = {31'd0, ($signed(a) < $signed(b))};
            end
            mrex_pkg::FN_SLTU: begin wr = 1'b1; dv = {31'd0, dif[32]}; end
            mrex_pkg::FN_SLL, mrex_pkg::FN_SRL, mrex_pkg::FN_SRA,
            mrex_pkg::FN_SLLV, mrex_pkg::FN_SRLV, mrex_pkg::FN_SRAV: begin
                wr = 1'b1; dv = shres;
            end
            mrex_pkg::FN_MFHI: begin wr = 1'b1; dv = hi_reg; end
            mrex_pkg::FN_MFLO: begin wr = 1'b1; dv = lo_reg; end
            mrex_pkg::FN_MTHI, mrex_pkg::FN_MTLO, mrex_pkg::FN_MULT,
            mrex_pkg::FN_MULTU, mrex_pkg::FN_DIV, mrex_pkg::FN_DIVU: begin
            end
            mrex_pkg::FN_JR: begin
                if (a[1:0] != 2'd0) fault = mrex_pkg::FAULT_ALIGN;
                else next_pc = a;
            end
            mrex_pkg::FN_JALR: begin
                if (rd == 5'd0) di = 5'd31;
                wr = 1'b1;
                dv = pc_reg + 32'd8;
                next_pc = (a[1:0] != 2'd0) ? fault_target_reg : a;
            end
            default: fault = mrex_pkg::FAULT_RESERVED;
        endcase
        if (fault != mrex_pkg::FAULT_NONE) begin
            next_pc = npc_reg;
            wr = 1'b0;
        end
        if (cmd_reg) begin
            fault = mrex_pkg::FAULT_NONE;
            next_pc = npc_reg;
            wr = 1'b1;
            di = ldi_reg;
            dv = ldv_reg;
        end
        if (di == 5'd0) wr = 1'b0;
        if (!wr) begin
            di = 5'd0;
            dv = 32'd0;
        end
    end

    always_comb begin
        state_next = state_reg;
        clr_next = clr_reg;
        hi_next = hi_reg;
        lo_next = lo_reg;
        out_next = out_reg;
        rf_we = 1'b0;
        rf_waddr = di;
        rf_wdata = dv;
        ictrl.start = 1'b0;
        ictrl.op = mrex_pkg::IT_NONE;
        ictrl.sign_a = 1'b0;
        ictrl.sign_b = 1'b0;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        unique case (state_reg)
            mrex_pkg::ST_IDLE: begin
                if (!clr_reg[5]) begin
                    rf_we = 1'b1;
                    rf_waddr = clr_reg[4:0];
                    rf_wdata = 32'd0;
                    clr_next = clr_reg + 6'd1;
                end else begin
                    s_axis_tready = 1'b1;
                    if (s_axis_tvalid) state_next = mrex_pkg::ST_READ;
                end
            end
            mrex_pkg::ST_READ: state_next = mrex_pkg::ST_EXEC;
            mrex_pkg::ST_EXEC: begin
                state_next = mrex_pkg::ST_FINISH;
                if (!cmd_reg) begin
                    case (fn)
                        mrex_pkg::FN_MULT, mrex_pkg::FN_MULTU: begin
                            ictrl.start = 1'b1;
                            ictrl.op = mrex_pkg::IT_MUL;
                            ictrl.sign_a = !fn[0];
                            ictrl.sign_b = !fn[0];
                            state_next = mrex_pkg::ST_ITER;
                        end
                        mrex_pkg::FN_DIV, mrex_pkg::FN_DIVU: begin
                            if (b != 32'd0) begin
                                ictrl.start = 1'b1;
                                ictrl.op = mrex_pkg::IT_DIV;
                                ictrl.sign_a = !fn[0];
                                ictrl.sign_b = !fn[0];
                                state_next = mrex_pkg::ST_ITER;
                            end
                        end
                        mrex_pkg::FN_MTHI: hi_next = a;
                        mrex_pkg::FN_MTLO: lo_next = a;
                        default: begin
                        end
                    endcase
                end
                rf_we = wr;
            end
            mrex_pkg::ST_ITER: begin
                if (istat.done) begin
                    hi_next = istat.hi;
                    lo_next = istat.lo;
                    state_next = mrex_pkg::ST_FINISH;
                end
            end
            mrex_pkg::ST_FINISH: begin
                out_next = {lo_reg, hi_reg, dv, di, wr, next_pc, fault};
                state_next = mrex_pkg::ST_OUT;
            end
            mrex_pkg::ST_OUT: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready) state_next = mrex_pkg::ST_IDLE;
            end
            default: state_next = mrex_pkg::ST_IDLE;
        endcase
    end

    assign m_axis_tdata = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mrex_pkg::ST_IDLE;
            clr_reg <= 6'd0;
            hi_reg <= 32'd0;
            lo_reg <= 32'd0;
            fault_target_reg <= FAULT_TARGET_INIT;
        end else begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            hi_reg <= hi_next;
            lo_reg <= lo_next;
            if (cfg_we) fault_target_reg <= cfg_wdata;
        end
        out_reg <= out_next;
        if (s_axis_tvalid && s_axis_tready) begin
            cmd_reg <= s_axis_tuser;
            ins_reg <= s_axis_tdata[31:0];
            pc_reg <= s_axis_tdata[63:32];
            npc_reg <= s_axis_tdata[95:64];
            ldi_reg <= s_axis_tdata[100:96];
            ldv_reg <= s_axis_tdata[132:101];
        end
    end

endmodule

// File: sv/mrex_regfile.sv
// 32-entry general register file, one write and two registered reads
module mrex_regfile (
    input  logic        aclk,
    input  logic        we,
    input  logic [4:0]  waddr,
    input  logic [31:0] wdata,
    input  logic [4:0]  raddr_a,
    input  logic [4:0]  raddr_b,
    output logic [31:0] rdata_a,
    output logic [31:0] rdata_b
);

    logic [31:0] mem [mrex_pkg::REG_COUNT];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// File: sv/mrex_iter_unit.sv
// shared iterative unit: radix-2 shift-add multiply and restoring divide
module mrex_iter_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mrex_pkg::iter_ctrl_t ctrl,
    input  logic [31:0]          op_a,
    input  logic [31:0]          op_b,
    output mrex_pkg::iter_stat_t stat
);

    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    mrex_pkg::iter_op_t op_reg, op_next;
    logic        neg_q_reg, neg_q_next;
    logic        neg_r_reg, neg_r_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] qr_reg, qr_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [32:0] sum;
    logic [32:0] trial;
    logic [63:0] prod;
    logic [31:0] ua, ub;

    always_comb begin
        ua = (ctrl.sign_a && op_a[31]) ? (32'd0 - op_a) : op_a;
        ub = (ctrl.sign_b && op_b[31]) ? (32'd0 - op_b) : op_b;
        sum = {1'b0, acc_reg} + (qr_reg[0] ? {1'b0, dvs_reg} : 33'd0);
        trial = {acc_reg, qr_reg[31]} - {1'b0, dvs_reg};
        prod = {acc_reg, qr_reg};
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next = op_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        acc_next = acc_reg;
        qr_next = qr_reg;
        dvs_next = dvs_reg;
        if (ctrl.start) begin
            busy_next = 1'b1;
            cnt_next = 6'd0;
            op_next = ctrl.op;
            acc_next = 32'd0;
            qr_next = ua;
            dvs_next = ub;
            neg_q_next = (ctrl.sign_a && op_a[31]) ^ (ctrl.sign_b && op_b[31]);
            neg_r_next = ctrl.sign_a && op_a[31];
            if (ctrl.op == mrex_pkg::IT_MUL) begin
                neg_r_next = 1'b0;
            end
        end else if (busy_reg) begin
            if (cnt_reg == 6'd32) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (op_reg == mrex_pkg::IT_MUL) begin
                    if (neg_q_reg) begin
                        prod = 64'd0 - prod;
                    end
                    acc_next = prod[63:32];
                    qr_next = prod[31:0];
                end else begin
                    if (neg_q_reg) qr_next = 32'd0 - qr_reg;
                    if (neg_r_reg) acc_next = 32'd0 - acc_reg;
                end
            end else begin
                cnt_next = cnt_reg + 6'd1;
                if (op_reg == mrex_pkg::IT_MUL) begin
                    acc_next = sum[32:1];
                    qr_next = {sum[0], qr_reg[31:1]};
                end else if (!trial[32]) begin
                    acc_next = trial[31:0];
                    qr_next = {qr_reg[30:0], 1'b1};
                end else begin
                    acc_next = {acc_reg[30:0], qr_reg[31]};
                    qr_next = {qr_reg[30:0], 1'b0};
                end
            end
        end
        stat.done = done_reg;
        stat.hi = acc_reg;
        stat.lo = qr_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= 6'd0;
            op_reg <= mrex_pkg::IT_NONE;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
            op_reg <= op_next;
        end
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
        acc_reg <= acc_next;
        qr_reg <= qr_next;
        dvs_reg <= dvs_next;
    end

endmodule

// File: tb/tb_top.sv
// self-checking testbench for the r-type execute unit with random stimulus and stalls
module tb_top;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [31:0]  cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;  // instruction, pc, next_pc_in, load_index, load_value
    logic         s_axis_tuser;  // command
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [135:0] m_axis_tdata;  // fault, next_pc_out, wrote_reg, dest_index, dest_value, hi, lo

    localparam logic CMD_EXEC = 1'b0;
    localparam logic CMD_LOAD = 1'b1;
    localparam int   CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] dv;
        logic [4:0]  di;
        logic        wrote;
        logic [31:0] npc;
        logic [1:0]  fault;
    } outcome_t;

    mips_rtype_execute_unit dut (.*);

    logic [31:0] gpr [32];
    logic [31:0] hi_q, lo_q, trap_pc;
    outcome_t    pending_q [$];
    int          errors = 0;
    int          cycles = 0;
    bit          send_gaps = 1, recv_gaps = 1;
    int          hold_off = 0;

    mrex_pkg::funct_t fn_list [25] = '{mrex_pkg::FN_SLL, mrex_pkg::FN_SRL, mrex_pkg::FN_SRA,
        mrex_pkg::FN_SLLV, mrex_pkg::FN_SRLV, mrex_pkg::FN_SRAV, mrex_pkg::FN_JR,
        mrex_pkg::FN_JALR, mrex_pkg::FN_MFHI, mrex_pkg::FN_MTHI, mrex_pkg::FN_MFLO,
        mrex_pkg::FN_MTLO, mrex_pkg::FN_MULT, mrex_pkg::FN_MULTU, mrex_pkg::FN_DIV,
        mrex_pkg::FN_DIVU, mrex_pkg::FN_ADD, mrex_pkg::FN_ADDU, mrex_pkg::FN_SUB,
        mrex_pkg::FN_SUBU, mrex_pkg::FN_AND, mrex_pkg::FN_OR, mrex_pkg::FN_XOR,
        mrex_pkg::FN_SLT, mrex_pkg::FN_SLTU};

    always begin
        aclk = 1'b1; #2;
        aclk = 1'b0; #2;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL mips_rtype_execute_unit");
            $finish;
        end
    end

    function automatic outcome_t execute(logic cmd, logic [31:0] ins, logic [31:0] pc,
                                         logic [31:0] npc, logic [4:0] li, logic [31:0] lv);
        outcome_t o;
        logic [31:0] a, b, r, ua, ub, q, m;
        logic [4:0]  sh, va;
        logic [63:0] p;
        logic        wr, na, nb;
        o = '0;
        wr = 1'b0;
        o.npc = npc;
        if (cmd == CMD_LOAD) begin
            o.di = li; o.dv = lv; wr = 1'b1;
        end else begin
            a = gpr[ins[25:21]];
            b = gpr[ins[20:16]];
            o.di = ins[15:11];
            sh = ins[10:6];
            va = a[4:0];
            o.npc = npc + 32'd4;
            case (ins[5:0])
                mrex_pkg::FN_ADD: begin
                    r = a + b;
                    if (((a ^ r) & (b ^ r)) >> 31) o.fault = mrex_pkg::FAULT_OVERFLOW;
                    else begin wr = 1; o.dv = r; end
                end
                mrex_pkg::FN_ADDU: begin wr = 1; o.dv = a + b; end
                mrex_pkg::FN_SUB: begin
                    r = a - b;
                    if (((a ^ b) & (a ^ r)) >> 31) o.fault = mrex_pkg::FAULT_OVERFLOW;
                    else begin wr = 1; o.dv = r; end
                end
                mrex_pkg::FN_SUBU: begin wr = 1; o.dv = a - b; end
                mrex_pkg::FN_AND: begin wr = 1; o.dv = a & b; end
                mrex_pkg::FN_OR: begin wr = 1; o.dv = a | b; end
                mrex_pkg::FN_XOR: begin wr = 1; o.dv = a ^ b; end
                mrex_pkg::FN_SLT: begin wr = 1; o.dv = {31'd0, $signed(a) < $signed(b)}; end
                mrex_pkg::FN_SLTU: begin wr = 1; o.dv = {31'd0, a < b}; end
                mrex_pkg::FN_SLL: begin wr = 1; o.dv = b << sh; end
                mrex_pkg::FN_SRL: begin wr = 1; o.dv = b >> sh; end
                mrex_pkg::FN_SRA: begin wr = 1; o.dv = $signed(b) >>> sh; end
                mrex_pkg::FN_SLLV: begin wr = 1; o.dv = b << va; end
                mrex_pkg::FN_SRLV: begin wr = 1; o.dv = b >> va; end
                mrex_pkg::FN_SRAV: begin wr = 1; o.dv = $signed(b) >>> va; end
                mrex_pkg::FN_MULT: begin
                    p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                    hi_q = p[63:32]; lo_q = p[31:0];
                end
                mrex_pkg::FN_MULTU: begin
                    p = {32'd0, a} * {32'd0, b};
                    hi_q = p[63:32]; lo_q = p[31:0];
                end
                mrex_pkg::FN_DIV: if (b != 0) begin
                    na = a[31]; nb = b[31];
                    ua = na ? -a : a;
                    ub = nb ? -b : b;
                    q = ua / ub; m = ua % ub;
                    lo_q = (na != nb) ? -q : q;
                    hi_q = na ? -m : m;
                end
                mrex_pkg::FN_DIVU: if (b != 0) begin lo_q = a / b; hi_q = a % b; end
                mrex_pkg::FN_MFHI: begin wr = 1; o.dv = hi_q; end
                mrex_pkg::FN_MFLO: begin wr = 1; o.dv = lo_q; end
                mrex_pkg::FN_MTHI: hi_q = a;
                mrex_pkg::FN_MTLO: lo_q = a;
                mrex_pkg::FN_JR: begin
                    if (a[1:0] != 0) o.fault = mrex_pkg::FAULT_ALIGN;
                    else o.npc = a;
                end
                mrex_pkg::FN_JALR: begin
                    if (o.di == 0) o.di = 5'd31;
                    wr = 1; o.dv = pc + 32'd8;
                    o.npc = (a[1:0] != 0) ? trap_pc : a;
                end
                default: o.fault = mrex_pkg::FAULT_RESERVED;
            endcase
            if (o.fault != mrex_pkg::FAULT_NONE) begin o.npc = npc; wr = 0; end
        end
        if (wr && o.di == 0) wr = 0;
        if (wr) gpr[o.di] = o.dv;
        else begin o.di = 0; o.dv = 0; end
        o.wrote = wr;
        o.hi = hi_q; o.lo = lo_q;
        return o;
    endfunction

    task automatic send_item(logic cmd, logic [31:0] ins, logic [31:0] pc, logic [31:0] npc,
                             logic [4:0] li, logic [31:0] lv);
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {3'd0, lv, li, npc, pc, ins};
        do @(posedge aclk); while (!s_axis_tready);
        pending_q.push_back(execute(cmd, ins, pc, npc, li, lv));
        @(negedge aclk);
    endtask

    // receiver with random stalls and one long hold-off
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off > 0) begin
                m_axis_tready <= 1'b0;
                hold_off = hold_off - 1;
            end else if (recv_gaps && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge aclk);
                m_axis_tready <= 1'b1;
            end else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        outcome_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pending_q.size() == 0) begin
                $display("%0t unexpected transfer %h", $time, got);
                errors++;
            end else begin
                want = pending_q.pop_front();
                if (got.fault !== want.fault)
                    $display("%0t fault exp %h got %h", $time, want.fault, got.fault);
                if (got.npc !== want.npc)
                    $display("%0t next_pc exp %h got %h", $time, want.npc, got.npc);
                if (got.wrote !== want.wrote)
                    $display("%0t wrote_reg exp %h got %h", $time, want.wrote, got.wrote);
                if (got.di !== want.di)
                    $display("%0t dest_index exp %h got %h", $time, want.di, got.di);
                if (got.dv !== want.dv)
                    $display("%0t dest_value exp %h got %h", $time, want.dv, got.dv);
                if (got.hi !== want.hi)
                    $display("%0t hi exp %h got %h", $time, want.hi, got.hi);
                if (got.lo !== want.lo)
                    $display("%0t lo exp %h got %h", $time, want.lo, got.lo);
                if (got !== want) errors++;
            end
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(0, 40);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] make_ins(mrex_pkg::funct_t fn, int rs, int rt, int rd,
                                             int sh);
        return {6'd0, 5'(rs), 5'(rt), 5'(rd), 5'(sh), 6'(fn)};
    endfunction

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic write_trap(logic [31:0] v);
        cfg_we <= 1'b1; cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
        trap_pc = v;
    endtask

    task automatic load(int r, logic [31:0] v);
        send_item(CMD_LOAD, $urandom, $urandom, $urandom, 5'(r), v);
    endtask

    task automatic exec(logic [31:0] ins);
        send_item(CMD_EXEC, ins, $urandom, $urandom, 5'($urandom), $urandom);
    endtask

    task automatic test_directed();
        load(1, 32'h7FFF_FFFF); load(2, 32'h8000_0000); load(3, 32'hFFFF_FFFF);
        load(0, 32'h1234_5678); load(4, 32'h0000_0103);
        exec(make_ins(mrex_pkg::FN_ADD, 1, 1, 5, 0));
        exec(make_ins(mrex_pkg::FN_SUB, 2, 1, 5, 0));
        exec(make_ins(mrex_pkg::FN_DIV, 2, 3, 0, 0));
        exec(make_ins(mrex_pkg::FN_MFLO, 0, 0, 6, 0));
        exec(make_ins(mrex_pkg::FN_DIVU, 1, 0, 0, 0));
        exec(make_ins(mrex_pkg::FN_SRA, 0, 2, 7, 31));
        exec(make_ins(mrex_pkg::FN_SRAV, 3, 2, 7, 0));
        exec(make_ins(mrex_pkg::FN_JR, 4, 0, 0, 0));
        exec(make_ins(mrex_pkg::FN_JALR, 4, 0, 0, 0));
        exec(make_ins(mrex_pkg::FN_JALR, 0, 0, 9, 0));
        exec(make_ins(mrex_pkg::FN_MULT, 2, 3, 0, 0));
        exec(make_ins(mrex_pkg::FN_ADDU, 1, 1, 0, 0));
        exec(32'hFFFF_FFFF);
        exec({26'h3FF_FFFF, 6'h3F});
        foreach (fn_list[i]) exec(make_ins(fn_list[i], 1 + i % 4, 3 - i % 3, 10 + i % 8, i));
        send_item(CMD_EXEC, make_ins(mrex_pkg::FN_JALR, 0, 0, 0, 0), 32'hFFFF_FFFC,
                  32'hFFFF_FFFC, 5'd31, 32'hFFFF_FFFF);
    endtask

    task automatic test_random(int n);
        mrex_pkg::funct_t fn;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0)
                load($urandom_range(0, 31), pick_value());
            else if ($urandom_range(0, 19) == 0)
                exec($urandom);
            else begin
                fn = fn_list[$urandom_range(0, 24)];
                exec({6'($urandom), 5'($urandom), 5'($urandom), 5'($urandom),
                      5'($urandom), 6'(fn)});
            end
        end
    endtask

    task automatic test_backpressure();
        hold_off = 300;
        test_random(20);
    endtask

    initial begin
        for (int i = 0; i < 32; i++) gpr[i] = '0;
        hi_q = '0; lo_q = '0; trap_pc = mrex_pkg::FAULT_TARGET_RESET;
        aresetn = 1'b0; cfg_we = 1'b0; cfg_wdata = '0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        drain();
        write_trap(32'h0);
        test_random(300);
        test_backpressure();
        drain();
        write_trap(32'hFFFF_FFFF);
        test_random(300);
        drain();
        write_trap($urandom);
        test_random(400);
        send_gaps = 0; recv_gaps = 0;
        test_random(150);
        drain();
        if (errors == 0) $display("PASS mips_rtype_execute_unit");
        else $display("FAIL mips_rtype_execute_unit");
        $finish;
    end
endmodule
